@@ rtl/fckvt_pkg.sv @@
// ----------------------------------------------------------------------------
// fckvt_pkg
// Shared types, codes and helpers for the fixed-capacity key/value table.
// ----------------------------------------------------------------------------
package fckvt_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_BYTES_DEF = 8;

  // Command codes
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_UNSET = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // latch a new item
    logic do_cmp;    // compare key against all live entries
    logic do_apply;  // update the table and load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full;  // output register holds a result not yet taken
  } dp_status_t;

  // Key text ends at the first NUL byte or at nbytes, whichever comes first.
  function automatic logic [KEY_W-1:0] norm_key(logic [KEY_W-1:0] raw,
                                                 int unsigned nbytes);
    logic [KEY_W-1:0] r;
    logic             live;
    r    = '0;
    live = 1'b1;
    for (int unsigned b = 0; b < KEY_W / 8; b++) begin
      if (raw[8*b +: 8] == 8'd0 || b >= nbytes) live = 1'b0;
      if (live) r[8*b +: 8] = raw[8*b +: 8];
    end
    return r;
  endfunction

endpackage

@@ rtl/fixed_capacity_key_value_table.sv @@
// ----------------------------------------------------------------------------
// fixed_capacity_key_value_table
// Packed key/value table with set (update/insert) and unset (remove).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries command, key and value; a
//   transfer happens on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid/out_stall) carries status, entry_count and
//   empty_flag, one result per input item, in order.
//   After the input transfer the item is compared against all live entries
//   (S_CMP) and then applied (S_APPLY), which loads the result register.
//   The next item is taken in the apply cycle of the current one.
//   Reset empties the table (entry count zero) and drops any pending result;
//   in_stall stays high while rst is asserted.
//   Entry storage is not cleared; only live entries are ever compared.
//   When the receiver stalls, the result register holds; one more item can
//   be taken and compared, then in_stall rises until the result drains.
// ----------------------------------------------------------------------------
module fixed_capacity_key_value_table #(
  parameter int unsigned CAPACITY  = fckvt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = fckvt_pkg::KEY_BYTES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    command,
  input  logic [fckvt_pkg::KEY_W-1:0]             key,
  input  logic signed [fckvt_pkg::VALUE_W-1:0]    value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [fckvt_pkg::STATUS_W-1:0]          status,
  output logic [fckvt_pkg::COUNT_OUT_W-1:0]       entry_count,
  output logic                                    empty_flag
);

  fckvt_pkg::ctrl_cmd_t  cmd;
  fckvt_pkg::dp_status_t dp_sts;

  fckvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .dp_sts    (dp_sts),
    .cmd       (cmd)
  );

  fckvt_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .dp_sts      (dp_sts),
    .command     (command),
    .key         (key),
    .value       (value),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .entry_count (entry_count),
    .empty_flag  (empty_flag)
  );

endmodule

@@ rtl/fckvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// fckvt_ctrl
// Sequencer: accept, compare, apply. Issues datapath commands and handshakes.
// ----------------------------------------------------------------------------
module fckvt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   out_stall,
  input  fckvt_pkg::dp_status_t  dp_sts,
  output fckvt_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       can_load;
  logic       accept;

  // The output register can take a result if empty or being drained.
  assign can_load = !dp_sts.out_full || !out_stall;
  assign in_stall = rst || !((state == S_IDLE) || (state == S_APPLY && can_load));
  assign accept   = in_valid && !in_stall;

  assign cmd.load_in  = accept;
  assign cmd.do_cmp   = (state == S_CMP);
  assign cmd.do_apply = (state == S_APPLY) && can_load;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        // next item may enter while this one retires
        if (can_load) state_next = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/fckvt_dpath.sv @@
// ----------------------------------------------------------------------------
// fckvt_dpath
// Entry registers, parallel key compare, shift-down removal, result register.
// ----------------------------------------------------------------------------
module fckvt_dpath #(
  parameter int unsigned CAPACITY  = fckvt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = fckvt_pkg::KEY_BYTES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fckvt_pkg::ctrl_cmd_t                    cmd,
  output fckvt_pkg::dp_status_t                   dp_sts,
  input  logic                                    command,
  input  logic [fckvt_pkg::KEY_W-1:0]             key,
  input  logic signed [fckvt_pkg::VALUE_W-1:0]    value,
  input  logic                                    out_stall,
  output logic                                    out_valid,
  output logic [fckvt_pkg::STATUS_W-1:0]          status,
  output logic [fckvt_pkg::COUNT_OUT_W-1:0]       entry_count,
  output logic                                    empty_flag
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Latched item
  logic                                 cmd_q;
  logic [fckvt_pkg::KEY_W-1:0]          key_q;
  logic signed [fckvt_pkg::VALUE_W-1:0] value_q;

  // Entry storage, one register per slot
  logic [fckvt_pkg::KEY_W-1:0]          keys   [CAPACITY];
  logic signed [fckvt_pkg::VALUE_W-1:0] values [CAPACITY];
  logic [CNT_W-1:0]                     count;
  logic [CNT_W-1:0]                     count_next;

  logic [CAPACITY-1:0]                  match_q;
  logic [CAPACITY-1:0]                  match_now;
  logic [IDX_W-1:0]                     hit_idx;
  logic                                 hit;
  logic                                 full;
  logic [fckvt_pkg::STATUS_W-1:0]       status_next;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q   <= command;
      key_q   <= fckvt_pkg::norm_key(key, KEY_BYTES);
      value_q <= value;
    end
  end

  // Live entries hold unique keys, so at most one bit of the vector is set.
  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      match_now[i] = (CNT_W'(i) < count) && (keys[i] == key_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_cmp) match_q <= match_now;
  end

  always_comb begin
    hit_idx = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  assign hit  = |match_q;
  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    count_next  = count;
    status_next = fckvt_pkg::ST_UPDATED;
    if (cmd_q == fckvt_pkg::CMD_SET) begin
      if (hit) begin
        status_next = fckvt_pkg::ST_UPDATED;
      end else if (full) begin
        status_next = fckvt_pkg::ST_FULL;
      end else begin
        status_next = fckvt_pkg::ST_INSERTED;
        count_next  = count + 1'b1;
      end
    end else begin
      if (hit) begin
        status_next = fckvt_pkg::ST_REMOVED;
        count_next  = count - 1'b1;
      end else begin
        status_next = fckvt_pkg::ST_NOTFOUND;
      end
    end
  end

  // Each slot either takes a new value, takes the new entry, or copies its
  // upper neighbor when removal closes the gap.
  always_ff @(posedge clk) begin
    if (cmd.do_apply) begin
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        if (cmd_q == fckvt_pkg::CMD_SET) begin
          if (hit) begin
            if (match_q[i]) values[i] <= value_q;
          end else if (!full && CNT_W'(i) == count) begin
            keys[i]   <= key_q;
            values[i] <= value_q;
          end
        end else if (hit && (i + 1 < CAPACITY) && (IDX_W'(i) >= hit_idx)) begin
          keys[i]   <= keys[(i + 1) % CAPACITY];
          values[i] <= values[(i + 1) % CAPACITY];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_apply) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_apply) begin
      status      <= status_next;
      entry_count <= fckvt_pkg::COUNT_OUT_W'(count_next);
      empty_flag  <= (count_next == '0);
    end
  end

  assign dp_sts.out_full = out_valid;

endmodule

@@ rtl/fckvt_checker.sv @@
// ----------------------------------------------------------------------------
// fckvt_checker
// Port-level checks for the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module fckvt_checker #(
  parameter int unsigned CAPACITY = fckvt_pkg::CAPACITY_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [fckvt_pkg::STATUS_W-1:0]     status,
  input logic [fckvt_pkg::COUNT_OUT_W-1:0]  entry_count,
  input logic                               empty_flag
);

  // A stalled result must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (empty_flag == (entry_count == '0)))
    else $error("empty_flag disagrees with entry_count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((CAPACITY > 31) || (entry_count <= CAPACITY)))
    else $error("entry_count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fckvt_pkg::ST_FULL)
      |-> (entry_count == fckvt_pkg::COUNT_OUT_W'(CAPACITY)))
    else $error("table full reported below capacity");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fckvt_pkg::ST_INSERTED || status == fckvt_pkg::ST_UPDATED)
      |-> !empty_flag)
    else $error("empty table after set");

endmodule

bind fixed_capacity_key_value_table fckvt_checker #(.CAPACITY(CAPACITY)) u_fckvt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .entry_count (entry_count),
  .empty_flag  (empty_flag)
);

@@ verif/fixed_capacity_key_value_table_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_capacity_key_value_table_tb
// Self-checking bench for the key/value table. A scoreboard keeps its own
// list of live keys, predicts status, entry count and empty flag for every
// accepted command, and checks results in order. Stimulus is a directed
// pass (empty/full table, update, junk after NUL, removal at head, middle
// and tail) followed by random set/unset traffic over a small key pool,
// with bursty input, random output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module fixed_capacity_key_value_table_tb;

  localparam int CAPACITY    = fckvt_pkg::CAPACITY_DEF;
  localparam int KEY_BYTES   = fckvt_pkg::KEY_BYTES_DEF;
  localparam int RAND_ITEMS  = 830;
  localparam int POOL_SIZE   = 20;
  localparam int HOLD_CYCLES = 90;

  typedef struct packed {
    logic [fckvt_pkg::STATUS_W-1:0]    code;
    logic [fckvt_pkg::COUNT_OUT_W-1:0] count;
    logic                              empty;
  } kv_result_t;

  class kv_scoreboard;
    logic [fckvt_pkg::KEY_W-1:0] live_keys[$];
    kv_result_t                  due[$];
    int                          fails;
    int                          checked;
    int                          peak;
    int                          seen[5];

    // key text stops at the first NUL byte and at KEY_BYTES
    function logic [fckvt_pkg::KEY_W-1:0] text_of(logic [fckvt_pkg::KEY_W-1:0] raw);
      logic [fckvt_pkg::KEY_W-1:0] t;
      t = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
        if (raw[8*b +: 8] == 8'd0) break;
        t[8*b +: 8] = raw[8*b +: 8];
      end
      return t;
    endfunction

    function void note_input(logic cmd, logic [fckvt_pkg::KEY_W-1:0] raw);
      logic [fckvt_pkg::KEY_W-1:0] k;
      int                          hit;
      kv_result_t                  r;
      k   = text_of(raw);
      hit = -1;
      foreach (live_keys[i])
        if (hit < 0 && live_keys[i] == k) hit = i;
      if (cmd == fckvt_pkg::CMD_SET) begin
        if (hit >= 0) r.code = fckvt_pkg::ST_UPDATED;
        else if (live_keys.size() >= CAPACITY) r.code = fckvt_pkg::ST_FULL;
        else begin
          live_keys.push_back(k);
          r.code = fckvt_pkg::ST_INSERTED;
        end
      end else if (hit < 0) begin
        r.code = fckvt_pkg::ST_NOTFOUND;
      end else begin
        // later entries slide down one place
        live_keys.delete(hit);
        r.code = fckvt_pkg::ST_REMOVED;
      end
      r.count = fckvt_pkg::COUNT_OUT_W'(live_keys.size());
      r.empty = (live_keys.size() == 0);
      if (live_keys.size() > peak) peak = live_keys.size();
      due.push_back(r);
    endfunction

    function void check_result(logic [fckvt_pkg::STATUS_W-1:0] code,
                               logic [fckvt_pkg::COUNT_OUT_W-1:0] count,
                               logic empty);
      kv_result_t want;
      if (due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: status %0d count %0d empty %0b, none outstanding",
                   code, count, empty);
        return;
      end
      want = due.pop_front();
      checked++;
      if (code < 5) seen[code]++;
      if (code !== want.code || count !== want.count || empty !== want.empty) begin
        fails++;
        if (fails <= 10)
          $display("mismatch %0d: expected status %0d count %0d empty %0b, got %0d %0d %0b",
                   checked, want.code, want.count, want.empty, code, count, empty);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst;
  logic                                   in_valid;
  logic                                   in_stall;
  logic                                   command;
  logic [fckvt_pkg::KEY_W-1:0]            key;
  logic signed [fckvt_pkg::VALUE_W-1:0]   value;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [fckvt_pkg::STATUS_W-1:0]         status;
  logic [fckvt_pkg::COUNT_OUT_W-1:0]      entry_count;
  logic                                   empty_flag;

  kv_scoreboard sb = new();
  int           burst_left = 0;
  int           rush = 0;
  bit           hold_req = 1'b0;

  fixed_capacity_key_value_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .empty_flag  (empty_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [fckvt_pkg::KEY_W-1:0] random_text(int len);
    logic [fckvt_pkg::KEY_W-1:0] r;
    r = '0;
    for (int b = 0; b < len; b++) r[8*b +: 8] = 8'($urandom_range(1, 255));
    return r;
  endfunction

  // random bytes after the terminating NUL; must not change the key
  function automatic logic [fckvt_pkg::KEY_W-1:0] add_junk(logic [fckvt_pkg::KEY_W-1:0] k);
    int len;
    len = 8;
    for (int b = 0; b < 8; b++)
      if (k[8*b +: 8] == 8'd0 && len == 8) len = b;
    for (int b = len + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  // sender pacing: bursts of random length, random gaps, none while rushing
  task automatic pace();
    int gap;
    if (rush > 0) begin
      rush--;
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer(logic cmd, logic [fckvt_pkg::KEY_W-1:0] k,
                       logic [fckvt_pkg::VALUE_W-1:0] v);
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, k);
    pace();
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, entry_count, empty_flag);
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    int span;
    int cyc;
    cyc = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        cyc++;
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= (cyc % 3 == 0);
            default: out_stall <= ($urandom_range(0, 99) < 75);
          endcase
        end
        @(posedge clk);
      end
    end
  end

  // generous timeout: a correct run ends well before it
  initial begin
    #2000000;
    $display("fixed_capacity_key_value_table_tb failed");
    $finish;
  end

  initial begin
    logic [fckvt_pkg::KEY_W-1:0]   pool[POOL_SIZE];
    logic [fckvt_pkg::KEY_W-1:0]   k;
    logic [fckvt_pkg::VALUE_W-1:0] v;
    logic                          c;
    int                            set_pct;
    int                            pick;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= fckvt_pkg::CMD_SET;
    key      <= '0;
    value    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass
    offer(fckvt_pkg::CMD_UNSET, '0, 32'd5);                    // unset on empty table
    offer(fckvt_pkg::CMD_SET, '0, 32'h7FFF_FFFF);              // empty key is legal
    offer(fckvt_pkg::CMD_SET, '1, 32'h8000_0000);
    offer(fckvt_pkg::CMD_SET, 64'hFFFF_FFFF_FFFF_FF00, 32'd0); // junk after NUL = empty key
    offer(fckvt_pkg::CMD_SET, 64'hA5A5_A5A5_A500_6261, 32'd1); // "ab" with junk
    offer(fckvt_pkg::CMD_SET, 64'h0000_0000_0000_6261, 32'hFFFF_FFFF);
    for (int i = 0; i < CAPACITY - 3; i++)
      offer(fckvt_pkg::CMD_SET, {48'h0, 8'h30 + 8'(i), 8'h6B}, $urandom);
    offer(fckvt_pkg::CMD_SET, 64'h0000_0000_0000_7A7A, 32'd7); // new key on full table
    offer(fckvt_pkg::CMD_SET, 64'h0000_0000_0000_6261, 32'd9); // update on full table
    offer(fckvt_pkg::CMD_UNSET, '1, 32'd0);                    // middle entry
    offer(fckvt_pkg::CMD_UNSET, '0, 32'd0);                    // head entry
    offer(fckvt_pkg::CMD_UNSET, {48'h0, 8'h30 + 8'(CAPACITY - 4), 8'h6B}, 32'd0); // tail
    offer(fckvt_pkg::CMD_UNSET, 64'h1234_5600_0000_6261, 32'd0);
    offer(fckvt_pkg::CMD_UNSET, 64'h0000_0000_0000_7A7A, 32'd0); // missing key

    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++)
      pool[i] = random_text(($urandom_range(0, 2) == 0) ? $urandom_range(1, 8)
                                                        : $urandom_range(1, 3));

    set_pct = 70;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: set_pct = 80;
          1: set_pct = 30;
          default: set_pct = 55;
        endcase
      end
      if (n == 200) begin
        hold_req = 1'b1;
        rush     = 12;
      end
      c    = ($urandom_range(0, 99) < set_pct) ? fckvt_pkg::CMD_SET : fckvt_pkg::CMD_UNSET;
      pick = $urandom_range(0, 99);
      if (pick < 80) k = pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 90) k = add_junk(pool[$urandom_range(0, POOL_SIZE - 1)]);
      else k = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      offer(c, k, v);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results: updated %0d, inserted %0d, full %0d, removed %0d, missing %0d",
             sb.checked, sb.seen[fckvt_pkg::ST_UPDATED], sb.seen[fckvt_pkg::ST_INSERTED],
             sb.seen[fckvt_pkg::ST_FULL], sb.seen[fckvt_pkg::ST_REMOVED],
             sb.seen[fckvt_pkg::ST_NOTFOUND]);
    $display("peak occupancy %0d of %0d, %0d mismatches", sb.peak, CAPACITY, sb.fails);
    if (sb.fails == 0)
      $display("fixed_capacity_key_value_table_tb passed");
    else
      $display("fixed_capacity_key_value_table_tb failed");
    $finish;
  end

endmodule
